// ===== rtl/core/hrht_pkg.sv =====
package hrht_pkg;

    typedef enum logic [2:0] {
        PH_REQ     = 3'd0,
        PH_KEY     = 3'd1,
        PH_VAL     = 3'd2,
        PH_OK      = 3'd3,
        PH_BADLINE = 3'd4,
        PH_BADHDR  = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        FID_NONE    = 3'd0,
        FID_METHOD  = 3'd1,
        FID_URI     = 3'd2,
        FID_VERSION = 3'd3,
        FID_HOST    = 3'd4,
        FID_AGENT   = 3'd5
    } t_field_id;

    typedef enum logic [2:0] {
        ST_PARSING    = 3'd0,
        ST_COMPLETE   = 3'd1,
        ST_INCOMPLETE = 3'd2,
        ST_BAD_LINE   = 3'd3,
        ST_BAD_HEADER = 3'd4
    } t_status;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [2:0] HOST_KEY_LEN  = 3'd4;
    localparam logic [3:0] AGENT_KEY_LEN = 4'd10;
    localparam logic [2:0] HOST_DEAD     = 3'd7;
    localparam logic [3:0] AGENT_DEAD    = 4'd15;

    localparam logic [5:0] SPACE_MAX = 6'd63;

    function automatic logic [7:0] host_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0: c = "H";
            2'd1: c = "o";
            2'd2: c = "s";
            2'd3: c = "t";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] agent_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0: c = "U";
            4'd1: c = "s";
            4'd2: c = "e";
            4'd3: c = "r";
            4'd4: c = "-";
            4'd5: c = "A";
            4'd6: c = "g";
            4'd7: c = "e";
            4'd8: c = "n";
            4'd9: c = "t";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] host_feed(input logic [2:0] idx, input logic [7:0] c);
        logic [2:0] nidx;
        if (idx < HOST_KEY_LEN && c == host_char(idx[1:0])) begin
            nidx = idx + 3'd1;
        end else begin
            nidx = HOST_DEAD;
        end
        return nidx;
    endfunction

    function automatic logic [3:0] agent_feed(input logic [3:0] idx, input logic [7:0] c);
        logic [3:0] nidx;
        if (idx < AGENT_KEY_LEN && c == agent_char(idx)) begin
            nidx = idx + 4'd1;
        end else begin
            nidx = AGENT_DEAD;
        end
        return nidx;
    endfunction

endpackage

// ===== rtl/core/hrht_in_if.sv =====
interface hrht_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_in_buffer;

    modport source (output valid, output data_byte, output last_in_buffer, input ready);
    modport sink (input valid, input data_byte, input last_in_buffer, output ready);
endinterface

// ===== rtl/core/hrht_out_if.sv =====
interface hrht_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] field_id;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       cr_before;
    logic [5:0] spaces_before;
    logic       value_restart;
    logic [2:0] status;

    modport source (
        output valid, output field_id, output byte_valid, output out_byte,
        output cr_before, output spaces_before, output value_restart, output status,
        input ready
    );
    modport sink (
        input valid, input field_id, input byte_valid, input out_byte,
        input cr_before, input spaces_before, input value_restart, input status,
        output ready
    );
endinterface

// ===== rtl/core/http_request_header_tokenizer_core.sv =====
// HTTP request header tokenizer.
// Bytes of a request buffer arrive on the i_in channel, one per transfer, with
// last_in_buffer marking the final byte of the buffer. For every input transfer
// exactly one result leaves on the o_out channel: the field tag, the byte when it
// is a method, URI or version byte or belongs to a Host or User-Agent value, a
// held lone CR, the released interior space count, a value restart flag and the
// parse status. The block has an input register and a result register with one
// layer of per-byte logic between them; the result of a byte passes from the input
// register into the result register when the receiver has room, and one byte per
// cycle is sustained while the receiver keeps up.
// When the receiver stalls, the result register holds its result and the input
// register takes one more byte; after that i_in.ready drops until o_out moves.
// A synchronous active-low reset empties both registers and returns the parser
// to the start of a request line. After the last byte of a buffer the parser
// starts over by itself. SPACE_COUNT_LIMIT caps the held space count, which
// never exceeds 63.
module http_request_header_tokenizer_core
    import hrht_pkg::*;
#(
    parameter int SPACE_COUNT_LIMIT = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hrht_in_if.sink     i_in,
    hrht_out_if.source  o_out
);

    localparam logic [5:0] SpaceCap =
        (SPACE_COUNT_LIMIT > 63) ? SPACE_MAX : 6'(SPACE_COUNT_LIMIT);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    t_phase     r_phase, n_phase;
    logic [1:0] r_sep, n_sep;
    logic       r_crp, n_crp;
    logic [2:0] r_hidx, n_hidx;
    logic [3:0] r_aidx, n_aidx;
    logic       r_kmis, n_kmis;
    t_field_id  r_tgt, n_tgt;
    logic       r_vst, n_vst;
    logic [5:0] r_held, n_held;
    logic       r_lempty, n_lempty;

    logic       r_out_valid;
    t_field_id  r_out_fid, n_out_fid;
    logic       r_out_bv, n_out_bv;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_crb, n_out_crb;
    logic [5:0] r_out_sp, n_out_sp;
    logic       r_out_rst, n_out_rst;
    t_status    r_out_st, n_out_st;

    logic       advance;
    logic       step;

    assign advance  = !r_out_valid || o_out.ready;
    assign step     = advance && r_in_valid;
    assign i_in.ready = !r_in_valid || advance;

    always_comb begin
        logic [7:0] b;
        logic [2:0] f;
        b = r_in_byte;
        f = 3'd0;

        n_phase  = r_phase;
        n_sep    = r_sep;
        n_crp    = r_crp;
        n_hidx   = r_hidx;
        n_aidx   = r_aidx;
        n_kmis   = r_kmis;
        n_tgt    = r_tgt;
        n_vst    = r_vst;
        n_held   = r_held;
        n_lempty = r_lempty;

        n_out_fid  = FID_NONE;
        n_out_bv   = 1'b0;
        n_out_byte = 8'h00;
        n_out_crb  = 1'b0;
        n_out_sp   = 6'd0;
        n_out_rst  = 1'b0;
        n_out_st   = ST_PARSING;

        case (r_phase)
            PH_REQ: begin
                if (r_crp && b == CH_LF) begin
                    n_crp = 1'b0;
                    if (r_sep == 2'd2) begin
                        n_phase  = PH_KEY;
                        n_hidx   = 3'd0;
                        n_aidx   = 4'd0;
                        n_kmis   = 1'b0;
                        n_tgt    = FID_NONE;
                        n_vst    = 1'b0;
                        n_held   = 6'd0;
                        n_lempty = 1'b1;
                    end else begin
                        n_phase  = PH_BADLINE;
                        n_out_st = ST_BAD_LINE;
                    end
                end else begin
                    f = (r_sep < 2'd3) ? ({1'b0, r_sep} + 3'd1) : 3'd0;
                    if (r_crp) begin
                        n_crp     = 1'b0;
                        n_out_crb = (f != 3'd0);
                    end
                    if (b == CH_CR) begin
                        n_crp = 1'b1;
                    end else if (b == CH_SP) begin
                        if (r_sep < 2'd3) begin
                            n_sep = r_sep + 2'd1;
                        end
                    end else if (f != 3'd0) begin
                        n_out_bv   = 1'b1;
                        n_out_byte = b;
                    end
                    if (n_out_bv || n_out_crb) begin
                        n_out_fid = t_field_id'(f);
                    end
                end
            end
            PH_KEY: begin
                if (r_crp && b == CH_LF) begin
                    n_crp    = 1'b0;
                    n_phase  = r_lempty ? PH_OK : PH_BADHDR;
                    n_out_st = r_lempty ? ST_COMPLETE : ST_BAD_HEADER;
                end else begin
                    if (r_crp) begin
                        n_crp    = 1'b0;
                        n_hidx   = host_feed(n_hidx, CH_CR);
                        n_aidx   = agent_feed(n_aidx, CH_CR);
                        n_kmis   = (n_hidx == HOST_DEAD) && (n_aidx == AGENT_DEAD);
                        n_lempty = 1'b0;
                    end
                    if (b == CH_CR) begin
                        n_crp = 1'b1;
                    end else if (b == CH_COLON) begin
                        n_lempty = 1'b0;
                        if (!n_kmis && n_hidx == HOST_KEY_LEN) begin
                            n_tgt = FID_HOST;
                        end else if (!n_kmis && n_aidx == AGENT_KEY_LEN) begin
                            n_tgt = FID_AGENT;
                        end else begin
                            n_tgt = FID_NONE;
                        end
                        n_phase = PH_VAL;
                        n_vst   = 1'b0;
                        n_held  = 6'd0;
                        if (n_tgt != FID_NONE) begin
                            n_out_fid = n_tgt;
                            n_out_rst = 1'b1;
                        end
                    end else begin
                        n_hidx   = host_feed(n_hidx, b);
                        n_aidx   = agent_feed(n_aidx, b);
                        n_kmis   = (n_hidx == HOST_DEAD) && (n_aidx == AGENT_DEAD);
                        n_lempty = 1'b0;
                    end
                end
            end
            PH_VAL: begin
                if (r_crp && b == CH_LF) begin
                    n_crp    = 1'b0;
                    n_phase  = PH_KEY;
                    n_hidx   = 3'd0;
                    n_aidx   = 4'd0;
                    n_kmis   = 1'b0;
                    n_tgt    = FID_NONE;
                    n_vst    = 1'b0;
                    n_held   = 6'd0;
                    n_lempty = 1'b1;
                end else begin
                    if (r_crp) begin
                        n_crp     = 1'b0;
                        n_out_crb = 1'b1;
                        n_out_sp  = n_vst ? n_held : 6'd0;
                        n_held    = 6'd0;
                        n_vst     = 1'b1;
                    end
                    if (b == CH_CR) begin
                        n_crp = 1'b1;
                    end else if (b == CH_SP) begin
                        if (n_vst && n_held < SpaceCap) begin
                            n_held = n_held + 6'd1;
                        end
                    end else begin
                        if (!n_out_crb) begin
                            n_out_sp = n_vst ? n_held : 6'd0;
                            n_held   = 6'd0;
                            n_vst    = 1'b1;
                        end
                        n_out_bv   = 1'b1;
                        n_out_byte = b;
                    end
                    if (r_tgt != FID_NONE && (n_out_bv || n_out_crb)) begin
                        n_out_fid = r_tgt;
                    end else begin
                        n_out_bv   = 1'b0;
                        n_out_byte = 8'h00;
                        n_out_crb  = 1'b0;
                        n_out_sp   = 6'd0;
                    end
                end
            end
            PH_OK: begin
                n_out_st = ST_COMPLETE;
            end
            PH_BADLINE: begin
                n_out_st = ST_BAD_LINE;
            end
            PH_BADHDR: begin
                n_out_st = ST_BAD_HEADER;
            end
            default: begin
                n_out_st = ST_PARSING;
            end
        endcase

        if (r_in_last) begin
            if (n_out_st == ST_PARSING) begin
                n_out_st = ST_INCOMPLETE;
            end
            n_phase  = PH_REQ;
            n_sep    = 2'd0;
            n_crp    = 1'b0;
            n_hidx   = 3'd0;
            n_aidx   = 4'd0;
            n_kmis   = 1'b0;
            n_tgt    = FID_NONE;
            n_vst    = 1'b0;
            n_held   = 6'd0;
            n_lempty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_REQ;
            r_sep       <= 2'd0;
            r_crp       <= 1'b0;
            r_hidx      <= 3'd0;
            r_aidx      <= 4'd0;
            r_kmis      <= 1'b0;
            r_tgt       <= FID_NONE;
            r_vst       <= 1'b0;
            r_held      <= 6'd0;
            r_lempty    <= 1'b1;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_phase  <= n_phase;
                r_sep    <= n_sep;
                r_crp    <= n_crp;
                r_hidx   <= n_hidx;
                r_aidx   <= n_aidx;
                r_kmis   <= n_kmis;
                r_tgt    <= n_tgt;
                r_vst    <= n_vst;
                r_held   <= n_held;
                r_lempty <= n_lempty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_in_buffer;
        end
        if (step) begin
            r_out_fid  <= n_out_fid;
            r_out_bv   <= n_out_bv;
            r_out_byte <= n_out_byte;
            r_out_crb  <= n_out_crb;
            r_out_sp   <= n_out_sp;
            r_out_rst  <= n_out_rst;
            r_out_st   <= n_out_st;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.field_id      = r_out_fid;
    assign o_out.byte_valid    = r_out_bv;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.cr_before     = r_out_crb;
    assign o_out.spaces_before = r_out_sp;
    assign o_out.value_restart = r_out_rst;
    assign o_out.status        = r_out_st;

endmodule

// ===== verif/http_request_header_tokenizer_core_checker.sv =====
`timescale 1ns / 1ps

module http_request_header_tokenizer_core_checker
    import hrht_pkg::*;
#(
    parameter int SPACE_COUNT_LIMIT = 63
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hrht_in_if   i_in,
    hrht_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    localparam logic [31:0] HOST_NAME  = "Host";
    localparam logic [79:0] AGENT_NAME = "User-Agent";
    localparam int          SPACE_CAP  = (SPACE_COUNT_LIMIT > 63) ? 63 : SPACE_COUNT_LIMIT;

    typedef struct packed {
        t_field_id  fid;
        logic       byte_ok;
        logic [7:0] data;
        logic       cr;
        logic [5:0] spaces;
        logic       restart;
        t_status    status;
    } t_byte_tag;

    t_phase     phase;
    logic [1:0] sep_count;
    logic       cr_held;
    logic [2:0] host_pos;
    logic [3:0] agent_pos;
    t_field_id  value_field;
    logic       value_begun;
    logic [5:0] held_spaces;
    logic       line_blank;

    t_byte_tag  predicted_tags[$];
    int         fail_count = 0;
    int         checked = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;

    task automatic report_error(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            report_error($sformatf("result %0d %s: got %0d, want %0d", checked, name, got, want));
        end
    endtask

    function automatic void begin_header_line();
        host_pos    = '0;
        agent_pos   = '0;
        value_field = FID_NONE;
        value_begun = 1'b0;
        held_spaces = '0;
        line_blank  = 1'b1;
    endfunction

    function automatic void clear_parser();
        phase     = PH_REQ;
        sep_count = '0;
        cr_held   = 1'b0;
        begin_header_line();
    endfunction

    function automatic void match_key(input logic [7:0] c);
        if (host_pos < HOST_KEY_LEN && c == HOST_NAME[31 - 8 * int'(host_pos) -: 8]) begin
            host_pos++;
        end else begin
            host_pos = HOST_DEAD;
        end
        if (agent_pos < AGENT_KEY_LEN && c == AGENT_NAME[79 - 8 * int'(agent_pos) -: 8]) begin
            agent_pos++;
        end else begin
            agent_pos = AGENT_DEAD;
        end
    endfunction

    function automatic t_byte_tag tag_next_byte(input logic [7:0] b, input logic last);
        t_byte_tag t;
        t_field_id slot;
        t        = '0;
        t.fid    = FID_NONE;
        t.status = ST_PARSING;
        case (phase)
            PH_REQ: begin
                if (cr_held && b == CH_LF) begin
                    cr_held = 1'b0;
                    if (sep_count == 2'd2) begin
                        phase = PH_KEY;
                        begin_header_line();
                    end else begin
                        phase    = PH_BADLINE;
                        t.status = ST_BAD_LINE;
                    end
                end else begin
                    slot = (sep_count == 2'd3) ? FID_NONE : t_field_id'({1'b0, sep_count} + 3'd1);
                    if (cr_held) begin
                        cr_held = 1'b0;
                        t.cr    = (slot != FID_NONE);
                    end
                    if (b == CH_CR) begin
                        cr_held = 1'b1;
                    end else if (b == CH_SP) begin
                        if (sep_count != 2'd3) begin
                            sep_count++;
                        end
                    end else if (slot != FID_NONE) begin
                        t.byte_ok = 1'b1;
                        t.data    = b;
                    end
                    if (t.byte_ok || t.cr) begin
                        t.fid = slot;
                    end
                end
            end
            PH_KEY: begin
                if (cr_held && b == CH_LF) begin
                    cr_held  = 1'b0;
                    phase    = line_blank ? PH_OK : PH_BADHDR;
                    t.status = line_blank ? ST_COMPLETE : ST_BAD_HEADER;
                end else begin
                    if (cr_held) begin
                        cr_held = 1'b0;
                        match_key(CH_CR);
                        line_blank = 1'b0;
                    end
                    if (b == CH_CR) begin
                        cr_held = 1'b1;
                    end else if (b == CH_COLON) begin
                        line_blank = 1'b0;
                        if (host_pos == HOST_KEY_LEN) begin
                            value_field = FID_HOST;
                        end else if (agent_pos == AGENT_KEY_LEN) begin
                            value_field = FID_AGENT;
                        end else begin
                            value_field = FID_NONE;
                        end
                        phase       = PH_VAL;
                        value_begun = 1'b0;
                        held_spaces = '0;
                        if (value_field != FID_NONE) begin
                            t.fid     = value_field;
                            t.restart = 1'b1;
                        end
                    end else begin
                        match_key(b);
                        line_blank = 1'b0;
                    end
                end
            end
            PH_VAL: begin
                if (cr_held && b == CH_LF) begin
                    cr_held = 1'b0;
                    phase   = PH_KEY;
                    begin_header_line();
                end else begin
                    if (cr_held) begin
                        cr_held     = 1'b0;
                        t.cr        = 1'b1;
                        t.spaces    = value_begun ? held_spaces : 6'd0;
                        held_spaces = '0;
                        value_begun = 1'b1;
                    end
                    if (b == CH_CR) begin
                        cr_held = 1'b1;
                    end else if (b == CH_SP) begin
                        if (value_begun && held_spaces < SPACE_CAP) begin
                            held_spaces++;
                        end
                    end else begin
                        if (!t.cr) begin
                            t.spaces    = value_begun ? held_spaces : 6'd0;
                            held_spaces = '0;
                            value_begun = 1'b1;
                        end
                        t.byte_ok = 1'b1;
                        t.data    = b;
                    end
                    if (value_field != FID_NONE && (t.byte_ok || t.cr)) begin
                        t.fid = value_field;
                    end else begin
                        t.byte_ok = 1'b0;
                        t.data    = '0;
                        t.cr      = 1'b0;
                        t.spaces  = '0;
                    end
                end
            end
            PH_OK: begin
                t.status = ST_COMPLETE;
            end
            PH_BADLINE: begin
                t.status = ST_BAD_LINE;
            end
            default: begin
                t.status = ST_BAD_HEADER;
            end
        endcase
        if (last) begin
            if (t.status == ST_PARSING) begin
                t.status = ST_INCOMPLETE;
            end
            clear_parser();
        end
        return t;
    endfunction

    always @(posedge i_clk) begin
        t_byte_tag want;
        if (!i_rst_n) begin
            clear_parser();
            predicted_tags.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                checked++;
                if (predicted_tags.size() == 0) begin
                    report_error($sformatf("result %0d arrived with nothing expected", checked));
                end else begin
                    want = predicted_tags.pop_front();
                    check_field("field_id", 8'(i_out.field_id), 8'(want.fid));
                    check_field("byte_valid", 8'(i_out.byte_valid), 8'(want.byte_ok));
                    check_field("out_byte", i_out.out_byte, want.data);
                    check_field("cr_before", 8'(i_out.cr_before), 8'(want.cr));
                    check_field("spaces_before", 8'(i_out.spaces_before), 8'(want.spaces));
                    check_field("value_restart", 8'(i_out.value_restart), 8'(want.restart));
                    check_field("status", 8'(i_out.status), 8'(want.status));
                end
            end
            if (i_in.valid && i_in.ready) begin
                predicted_tags = {predicted_tags,
                                  tag_next_byte(i_in.data_byte, i_in.last_in_buffer)};
            end
        end
        o_pending <= predicted_tags.size();
    end

endmodule

// ===== verif/http_request_header_tokenizer_core_tb.sv =====
`timescale 1ns / 1ps

module http_request_header_tokenizer_core_tb;
    import hrht_pkg::*;

    localparam int SPACE_COUNT_LIMIT = 63;
    localparam int BYTE_TARGET       = 750;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hrht_in_if  byte_if ();
    hrht_out_if token_if ();

    int         fail_count;
    int         pending_count;
    int         checked_count;
    int         bytes_sent = 0;
    int         buffers_sent = 0;
    logic       calm = 1'b0;
    logic [7:0] request_bytes[$];

    string near_keys[8] = '{"host", "Hos", "Hostt", "HOST",
                            "User-Agen", "User-agent", "User-Agentx", "Accept"};

    http_request_header_tokenizer_core #(
        .SPACE_COUNT_LIMIT(SPACE_COUNT_LIMIT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (token_if)
    );

    http_request_header_tokenizer_core_checker #(
        .SPACE_COUNT_LIMIT(SPACE_COUNT_LIMIT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (byte_if),
        .i_out        (token_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned gap_cycles();
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        request_bytes = {request_bytes, b};
    endfunction

    function automatic void add_text(input string s);
        foreach (s[i]) begin
            request_bytes = {request_bytes, s[i]};
        end
    endfunction

    function automatic void add_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    function automatic logic [7:0] random_glyph();
        logic [7:0] g;
        if ($urandom_range(0, 7) == 0) begin
            do g = 8'($urandom); while (g == CH_CR || g == CH_LF || g == CH_SP);
        end else begin
            g = 8'($urandom_range(33, 126));
        end
        return g;
    endfunction

    function automatic void add_word(input int unsigned len);
        repeat (len) begin
            if ($urandom_range(0, 24) == 0) begin
                add_byte(CH_CR);
            end
            add_byte(random_glyph());
        end
    endfunction

    function automatic void add_noise();
        repeat ($urandom_range(1, 24)) begin
            case ($urandom_range(0, 5))
                0: add_byte(CH_CR);
                1: add_byte(CH_LF);
                2: add_byte(CH_SP);
                3: add_byte(CH_COLON);
                default: add_byte(8'($urandom));
            endcase
        end
    endfunction

    function automatic void add_value();
        int unsigned words;
        repeat ($urandom_range(0, 3)) add_byte(CH_SP);
        words = $urandom_range(0, 4);
        for (int w = 0; w < words; w++) begin
            if (w != 0) begin
                if ($urandom_range(0, 14) == 0) begin
                    repeat ($urandom_range(60, 72)) add_byte(CH_SP);
                end else begin
                    repeat ($urandom_range(1, 4)) add_byte(CH_SP);
                end
            end
            add_word($urandom_range(1, 8));
        end
        repeat ($urandom_range(0, 3)) add_byte(CH_SP);
        if ($urandom_range(0, 14) == 0) begin
            add_byte(CH_CR);
        end
    endfunction

    function automatic void add_header_line();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            add_text("Host");
        end else if (pick < 65) begin
            add_text("User-Agent");
        end else if (pick < 85) begin
            add_text(near_keys[$urandom_range(0, 7)]);
        end else if (pick < 95) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(65, 90)));
        end
        if ($urandom_range(0, 19) == 0) begin
            add_byte(CH_CR);
            add_byte(8'($urandom_range(97, 122)));
        end
        if ($urandom_range(0, 14) == 0) begin
            add_crlf();
        end else begin
            add_byte(CH_COLON);
            add_value();
            add_crlf();
        end
    endfunction

    function automatic void build_request();
        int unsigned shape;
        int unsigned seps;
        int unsigned odd_seps[4] = '{0, 1, 3, 5};
        shape = $urandom_range(0, 99);
        if (shape < 8) begin
            add_noise();
            return;
        end
        seps = (shape < 18) ? odd_seps[$urandom_range(0, 3)] : 2;
        add_word($urandom_range(1, 7));
        repeat (seps) begin
            add_byte(CH_SP);
            if ($urandom_range(0, 7) != 0) begin
                add_word($urandom_range(1, 10));
            end
        end
        add_crlf();
        repeat ($urandom_range(0, 4)) add_header_line();
        add_crlf();
        if (shape >= 88) begin
            repeat ($urandom_range(1, request_bytes.size() - 1)) void'(request_bytes.pop_back());
        end else if (shape >= 80) begin
            add_noise();
        end
    endfunction

    task automatic send_request();
        int unsigned gap;
        foreach (request_bytes[k]) begin
            gap = gap_cycles();
            if (gap != 0) begin
                byte_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            byte_if.valid          <= 1'b1;
            byte_if.data_byte      <= request_bytes[k];
            byte_if.last_in_buffer <= (k == request_bytes.size() - 1);
            do @(posedge i_clk); while (!byte_if.ready);
            bytes_sent++;
        end
        request_bytes.delete();
        buffers_sent++;
    endtask

    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        byte_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending_count != 0 && waited < 5000);
    endtask

    initial begin
        token_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            int unsigned stall;
            stall = gap_cycles();
            if (stall != 0) begin
                token_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            token_if.ready <= 1'b1;
            do @(posedge i_clk); while (!token_if.valid);
        end
    end

    initial begin
        byte_if.valid          <= 1'b0;
        byte_if.data_byte      <= '0;
        byte_if.last_in_buffer <= 1'b0;
        i_rst_n                <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Extreme bytes, lone CR in the URI, empty and repeated Host values.
        add_byte(8'hFF);
        add_byte(CH_SP);
        add_byte(8'h00);
        add_byte(CH_CR);
        add_byte(CH_SP);
        add_text("V");
        add_crlf();
        add_text("Host:");
        add_crlf();
        add_text("Host: a  b ");
        add_crlf();
        add_crlf();
        send_request();
        // Request line with one space only.
        add_byte(CH_SP);
        add_crlf();
        send_request();
        // Header line without a colon.
        add_text("  ");
        add_crlf();
        add_text("H");
        add_crlf();
        send_request();
        // Buffer that ends on a lone LF.
        add_byte(CH_LF);
        send_request();
        drain_results();

        while (bytes_sent < BYTE_TARGET) begin
            calm = ($urandom_range(0, 5) == 0);
            build_request();
            if (request_bytes.size() != 0) begin
                send_request();
            end
            if (buffers_sent % 9 == 0) begin
                drain_results();
            end
        end
        calm = 1'b0;
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("run: %0d bytes in %0d buffers, %0d results checked, %0d mismatches",
                 bytes_sent, buffers_sent, checked_count, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
